>>> rtl/core/crcz_pkg.sv
// ----------------------------------------------------------------------------
// crcz_pkg
// Shared constants and elaboration-time helpers for the CRC-32 zero-byte
// extension pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package crcz_pkg;

  localparam int unsigned CrcW     = 32;
  localparam int unsigned CountW   = 64;
  localparam int unsigned TableLen = 32;
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 32;

  localparam logic [CrcW-1:0] CrcPoly = 32'hEDB8_8320;

  // Entry n is x^(8*2^n) mod P in reflected bit order.
  localparam logic [CrcW-1:0] PowerTable [TableLen] = '{
    32'h0080_0000, 32'h0000_8000, 32'hedb8_8320, 32'hb1e6_b092,
    32'ha06a_2517, 32'hed62_7dae, 32'h88d1_4467, 32'hd7bb_fe6a,
    32'hec44_7f11, 32'h8e7e_a170, 32'h6427_800e, 32'h4d47_bae0,
    32'h09fe_548f, 32'h8385_2d0f, 32'h3036_2f1a, 32'h7b5a_9cc3,
    32'h31fe_c169, 32'h9fec_022a, 32'h6c8d_edc4, 32'h15d6_874d,
    32'h5fde_7a4e, 32'hbad9_0e37, 32'h2e4e_5eef, 32'h4eab_a214,
    32'ha8a4_72c0, 32'h429a_969e, 32'h148d_302a, 32'hc40b_a6d0,
    32'hc4e2_2c3c, 32'h4000_0000, 32'h2000_0000, 32'h0800_0000
  };

  typedef logic [CrcW-1:0][CrcW-1:0] crc_matrix_t;

  typedef struct packed {
    logic [CrcW-1:0]   value;
    logic [CountW-1:0] count;
  } crcz_item_t;

  // GF(2) product of two reflected residues, used only to build constant matrices.
  function automatic logic [CrcW-1:0] gf_mul(input logic [CrcW-1:0] x_in,
                                             input logic [CrcW-1:0] y_in);
    logic [CrcW-1:0] acc;
    logic [CrcW-1:0] x;
    logic [CrcW-1:0] y;
    acc = '0;
    x   = x_in;
    y   = y_in;
    for (int s = 0; s < CrcW; s++) begin
      if (y[CrcW-1]) begin
        acc = acc ^ x;
      end
      if (x[0]) begin
        x = (x >> 1) ^ CrcPoly;
      end else begin
        x = x >> 1;
      end
      y = y << 1;
    end
    return acc;
  endfunction

  // Row j is the product of the unit residue with only bit j set and the constant.
  function automatic crc_matrix_t power_matrix(input logic [CrcW-1:0] power);
    crc_matrix_t m;
    for (int j = 0; j < CrcW; j++) begin
      m[j] = gf_mul(CrcW'(1) << j, power);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/crcz_stage.sv
// ----------------------------------------------------------------------------
// crcz_stage
// One pipeline stage: multiplies the residue by x^(8*2^n) when count bit n
// is set, as a constant GF(2) matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module crcz_stage #(
  parameter int unsigned BitIdx = 0
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                adv_i,
  input  wire logic                vld_i,
  input  wire crcz_pkg::crcz_item_t item_i,
  output logic                     vld_o,
  output crcz_pkg::crcz_item_t     item_o
);

  localparam logic [crcz_pkg::CrcW-1:0] Power =
    crcz_pkg::PowerTable[BitIdx % crcz_pkg::TableLen];
  localparam crcz_pkg::crc_matrix_t Matrix = crcz_pkg::power_matrix(Power);

  logic                 vld_q;
  crcz_pkg::crcz_item_t item_d;
  crcz_pkg::crcz_item_t item_q;
  logic [crcz_pkg::CrcW-1:0] prod;

  always_comb begin
    prod = '0;
    for (int j = 0; j < crcz_pkg::CrcW; j++) begin
      if (item_i.value[j]) begin
        prod = prod ^ Matrix[j];
      end
    end
    item_d       = item_i;
    if (item_i.count[BitIdx]) begin
      item_d.value = prod;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && vld_i) begin
      item_q <= item_d;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

`default_nettype wire

>>> rtl/core/crc32_zero_extend.sv
// ----------------------------------------------------------------------------
// crc32_zero_extend
// Extends a finished reflected CRC-32 over a run of appended zero bytes.
// ----------------------------------------------------------------------------
// Usage: an item on the slave stream carries the finished CRC in tdata bits
// 31:0 and the number of appended zero bytes in bits 95:32. The master
// stream returns one item per input item, in order, with the extended CRC.
// The block is a 64-stage pipeline, one stage per bit of the zero count,
// each stage a fixed GF(2) matrix product. Each stage registers the item,
// and one item can be accepted in every cycle while the receiver does not
// stall. All stages advance together; when the receiver stalls with a
// result waiting, the whole pipeline holds and s_axis_tready goes low, so
// nothing is dropped or repeated. Reset clears every stage valid bit and
// takes effect at once; the pipeline is ready in the first cycle after it.
// ----------------------------------------------------------------------------
`default_nettype none

module crc32_zero_extend (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // Fields from bit 0: crc_in[31:0], zero_count[95:32].
  input  wire logic [crcz_pkg::InDataW-1:0]      s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // Fields from bit 0: crc_out[31:0].
  output logic [crcz_pkg::OutDataW-1:0]          m_axis_tdata
);

  localparam int unsigned NumStages = crcz_pkg::CountW;

  logic                 adv;
  logic [NumStages:0]   vld;
  crcz_pkg::crcz_item_t item [NumStages+1];

  assign adv = !vld[NumStages] || m_axis_tready;

  assign vld[0]        = s_axis_tvalid;
  assign item[0].value = ~s_axis_tdata[crcz_pkg::CrcW-1:0];
  assign item[0].count = s_axis_tdata[crcz_pkg::CrcW +: crcz_pkg::CountW];

  for (genvar g = 0; g < NumStages; g++) begin : g_stage
    crcz_stage #(
      .BitIdx(g)
    ) u_stage (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .vld_i (vld[g]),
      .item_i(item[g]),
      .vld_o (vld[g+1]),
      .item_o(item[g+1])
    );
  end

  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[NumStages];
  assign m_axis_tdata  = ~item[NumStages].value;

  a_last_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && vld[NumStages-1] |=> m_axis_tvalid)
    else $error("item lost entering the last stage");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld[NumStages:1]))
    else $error("pipeline valid bits changed during a stall");

  a_bubble_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !s_axis_tvalid |=> !vld[1])
    else $error("first stage became valid without an accepted item");

endmodule

`default_nettype wire

>>> test/tb_crc32_zero_extend.sv
// ----------------------------------------------------------------------------
// tb_crc32_zero_extend
// Stream testbench for the CRC-32 zero-byte extension pipeline. A queue of
// directed and random items feeds a driver with random gaps. A monitor
// predicts each extended CRC by direct GF(2) arithmetic when its item is
// accepted, and checks results in order. The receiver stalls at random and
// once holds off long enough to back the pipeline up into its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_crc32_zero_extend;

  localparam int unsigned NumItems   = 1150;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 80;
  localparam int unsigned HoldAt     = 200;
  localparam int unsigned HoldLen    = 400;
  localparam logic [31:0] ReflPoly   = 32'hEDB8_8320;

  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  // Fields from bit 0: crc_in[31:0], zero_count[95:32].
  logic [crcz_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  // Fields from bit 0: crc_out[31:0].
  logic [crcz_pkg::OutDataW-1:0] m_axis_tdata;

  logic [crcz_pkg::InDataW-1:0] pending_items [$];
  logic [31:0]                  crc_due [$];
  logic [31:0]                  due_crc;
  logic                         in_took      = 1'b0;
  logic                         out_took     = 1'b0;
  int unsigned                  cycles       = 0;
  int unsigned                  errors       = 0;
  int unsigned                  results_seen = 0;
  int unsigned                  send_gap     = 0;
  int unsigned                  recv_wait    = 0;
  int unsigned                  recv_draw;
  int unsigned                  hold_left    = 0;
  logic                         hold_done    = 1'b0;
  logic                         send_burst   = 1'b0;
  logic                         recv_burst   = 1'b0;

  crc32_zero_extend dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // x^(8*2^n) mod P in reflected order, bit 31 standing for x^0.
  function automatic logic [31:0] zero_power(input logic [4:0] n);
    case (n)
      5'd0:    return 32'h0080_0000;
      5'd1:    return 32'h0000_8000;
      5'd2:    return 32'hedb8_8320;
      5'd3:    return 32'hb1e6_b092;
      5'd4:    return 32'ha06a_2517;
      5'd5:    return 32'hed62_7dae;
      5'd6:    return 32'h88d1_4467;
      5'd7:    return 32'hd7bb_fe6a;
      5'd8:    return 32'hec44_7f11;
      5'd9:    return 32'h8e7e_a170;
      5'd10:   return 32'h6427_800e;
      5'd11:   return 32'h4d47_bae0;
      5'd12:   return 32'h09fe_548f;
      5'd13:   return 32'h8385_2d0f;
      5'd14:   return 32'h3036_2f1a;
      5'd15:   return 32'h7b5a_9cc3;
      5'd16:   return 32'h31fe_c169;
      5'd17:   return 32'h9fec_022a;
      5'd18:   return 32'h6c8d_edc4;
      5'd19:   return 32'h15d6_874d;
      5'd20:   return 32'h5fde_7a4e;
      5'd21:   return 32'hbad9_0e37;
      5'd22:   return 32'h2e4e_5eef;
      5'd23:   return 32'h4eab_a214;
      5'd24:   return 32'ha8a4_72c0;
      5'd25:   return 32'h429a_969e;
      5'd26:   return 32'h148d_302a;
      5'd27:   return 32'hc40b_a6d0;
      5'd28:   return 32'hc4e2_2c3c;
      5'd29:   return 32'h4000_0000;
      5'd30:   return 32'h2000_0000;
      default: return 32'h0800_0000;
    endcase
  endfunction

  function automatic logic [31:0] gf2_mulmod(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] acc;
    logic [31:0] sh;
    acc = '0;
    sh  = a;
    for (int i = 31; i >= 0; i--) begin
      if (b[i]) begin
        acc = acc ^ sh;
      end
      sh = sh[0] ? ((sh >> 1) ^ ReflPoly) : (sh >> 1);
    end
    return acc;
  endfunction

  function automatic logic [31:0] extend_crc(input logic [31:0] crc, input logic [63:0] count);
    logic [31:0] v;
    v = ~crc;
    for (int n = 0; n < 64; n++) begin
      if (count[n]) begin
        v = gf2_mulmod(v, zero_power(n[4:0]));
      end
    end
    return ~v;
  endfunction

  function automatic int unsigned draw_gap(input logic burst);
    return burst ? 0 : $urandom_range(0, 4);
  endfunction

  task automatic queue_item(input logic [31:0] crc, input logic [63:0] count);
    pending_items.push_back({count, crc});
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles   <= cycles + 1;
    in_took  <= rst_ni && s_axis_tvalid && s_axis_tready;
    out_took <= rst_ni && m_axis_tvalid && m_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        crc_due.push_back(extend_crc(s_axis_tdata[31:0], s_axis_tdata[95:32]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen <= results_seen + 1;
        if (crc_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
          errors <= errors + 1;
        end else begin
          due_crc = crc_due.pop_front();
          if (m_axis_tdata !== due_crc) begin
            $display("%0t: crc_out mismatch, expected %h, actual %h",
                     $time, due_crc, m_axis_tdata);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && !in_took) begin
        s_axis_tvalid <= 1'b1;
      end else if (send_gap != 0) begin
        send_gap      <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        if ($urandom_range(0, 49) == 0) begin
          send_burst <= ~send_burst;
        end
        s_axis_tdata  <= pending_items.pop_front();
        s_axis_tvalid <= 1'b1;
        send_gap      <= draw_gap(send_burst);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && results_seen >= HoldAt) begin
        hold_done     <= 1'b1;
        hold_left     <= HoldLen;
        m_axis_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (out_took) begin
        if ($urandom_range(0, 49) == 0) begin
          recv_burst <= ~recv_burst;
        end
        recv_draw = draw_gap(recv_burst);
        if (recv_draw == 0) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          recv_wait     <= recv_draw - 1;
        end
      end else if (recv_wait != 0) begin
        recv_wait     <= recv_wait - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
    end
    $display("tb_crc32_zero_extend: errors");
    $finish;
  end

  initial begin
    logic [31:0] crc;
    logic [63:0] count;

    // Zero count leaves the CRC unchanged.
    queue_item(32'h0000_0000, 64'd0);
    queue_item(32'hFFFF_FFFF, 64'd0);
    queue_item(32'hCBF4_3926, 64'd0);
    queue_item(32'h0000_0000, '1);
    queue_item(32'hFFFF_FFFF, '1);
    queue_item(32'hCBF4_3926, 64'd1);
    queue_item(32'hCBF4_3926, 64'd2);
    queue_item(32'hCBF4_3926, 64'd4);
    queue_item(32'hCBF4_3926, 64'h8000_0000);
    // Count bits from 32 up reuse the table from its start.
    queue_item(32'hCBF4_3926, 64'h1_0000_0000);
    queue_item(32'hCBF4_3926, 64'h2_0000_0000);
    queue_item(32'hCBF4_3926, 64'h8000_0000_0000_0000);
    queue_item(32'h1234_5678, 64'hFFFF_FFFF_0000_0000);
    queue_item(32'h1234_5678, 64'h0000_0000_FFFF_FFFF);
    queue_item(32'hA5A5_A5A5, 64'h5555_5555_5555_5555);
    queue_item(32'h5A5A_5A5A, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_item(32'h8000_0001, 64'd1000);
    queue_item(32'h0000_0001, 64'h1_0000_0001);

    while (pending_items.size() < NumItems) begin
      case ($urandom_range(0, 7))
        0:       crc = 32'h0000_0000;
        1:       crc = 32'hFFFF_FFFF;
        default: crc = $urandom;
      endcase
      case ($urandom_range(0, 3))
        0:       count = {$urandom, $urandom};
        1:       count = 64'($urandom_range(0, 1023));
        2:       count = 64'd1 << $urandom_range(0, 63);
        default: count = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      endcase
      queue_item(crc, count);
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_items.size() != 0 || s_axis_tvalid) begin
      @(negedge clk_i);
    end
    while (crc_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainWait) @(negedge clk_i);
    if (errors == 0) begin
      $display("tb_crc32_zero_extend: clean");
    end else begin
      $display("tb_crc32_zero_extend: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
